// ===== rtl/core/tofc_pkg.sv =====
package tofc_pkg;

    localparam logic [7:0] IAC_BYTE  = 8'd255;
    localparam logic [7:0] DONT_BYTE = 8'd254;
    localparam logic [7:0] DO_BYTE   = 8'd253;
    localparam logic [7:0] WONT_BYTE = 8'd252;
    localparam logic [7:0] WILL_BYTE = 8'd251;
    localparam logic [7:0] SB_BYTE   = 8'd250;
    localparam logic [7:0] SE_BYTE   = 8'd240;

    typedef enum logic [4:0] {
        PH_DATA   = 5'b00001,
        PH_IAC    = 5'b00010,
        PH_VERB   = 5'b00100,
        PH_SUB    = 5'b01000,
        PH_SUBIAC = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        VERB_DO   = 2'd0,
        VERB_DONT = 2'd1,
        VERB_WILL = 2'd2,
        VERB_WONT = 2'd3
    } verb_t;

    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_DATA  = 2'd1,
        RES_REPLY = 2'd2
    } res_kind_t;

    typedef struct packed {
        res_kind_t  kind;
        logic [7:0] data;
        logic [7:0] reply_verb;
    } result_t;

endpackage

// ===== rtl/core/tofc_parser.sv =====
module tofc_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       in_byte,
    input  logic             advance,
    output tofc_pkg::result_t res
);
    import tofc_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    verb_t  verb_reg;
    verb_t  verb_next;

    always_comb begin
        phase_next     = phase_reg;
        verb_next      = verb_reg;
        res.kind       = RES_NONE;
        res.data       = in_byte;
        res.reply_verb = WONT_BYTE;
        unique case (phase_reg)
            PH_IAC: begin
                if (in_byte == IAC_BYTE) begin
                    phase_next = PH_DATA;
                    res.kind   = RES_DATA;
                end else if (in_byte == DO_BYTE || in_byte == DONT_BYTE ||
                             in_byte == WILL_BYTE || in_byte == WONT_BYTE) begin
                    phase_next = PH_VERB;
                    if (in_byte == DO_BYTE) begin
                        verb_next = VERB_DO;
                    end else if (in_byte == DONT_BYTE) begin
                        verb_next = VERB_DONT;
                    end else if (in_byte == WILL_BYTE) begin
                        verb_next = VERB_WILL;
                    end else begin
                        verb_next = VERB_WONT;
                    end
                end else begin
                    // SB opens a subnegotiation, any other command is dropped
                    phase_next = (in_byte == SB_BYTE) ? PH_SUB : PH_DATA;
                end
            end
            PH_VERB: begin
                phase_next = PH_DATA;
                if (verb_reg == VERB_DO) begin
                    res.kind       = RES_REPLY;
                    res.reply_verb = WONT_BYTE;
                end else if (verb_reg == VERB_WILL) begin
                    res.kind       = RES_REPLY;
                    res.reply_verb = DONT_BYTE;
                end
            end
            PH_SUB: begin
                phase_next = (in_byte == IAC_BYTE) ? PH_SUBIAC : PH_SUB;
            end
            PH_SUBIAC: begin
                phase_next = (in_byte == SE_BYTE) ? PH_DATA : PH_SUB;
            end
            default: begin
                if (in_byte == IAC_BYTE) begin
                    phase_next = PH_IAC;
                end else begin
                    phase_next = PH_DATA;
                    res.kind   = RES_DATA;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DATA;
            verb_reg  <= VERB_DO;
        end else if (advance) begin
            phase_reg <= phase_next;
            verb_reg  <= verb_next;
        end
    end

endmodule

// ===== rtl/core/tofc_emitter.sv =====
module tofc_emitter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tofc_pkg::result_t res,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_to_remote,
    output logic              m_last
);
    import tofc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic       beat_reg;
    logic       beat_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       remote_reg;
    logic       remote_next;
    logic       last_reg;
    logic       last_next;
    logic [7:0] verb_reg;
    logic [7:0] verb_next;
    logic [7:0] opt_reg;
    logic [7:0] opt_next;
    logic       done;
    logic       step;

    assign done     = valid_reg && m_ready && last_reg;
    assign step     = valid_reg && m_ready && !last_reg;
    assign can_load = !valid_reg || done;

    always_comb begin
        valid_next  = valid_reg;
        beat_next   = beat_reg;
        byte_next   = byte_reg;
        remote_next = remote_reg;
        last_next   = last_reg;
        verb_next   = verb_reg;
        opt_next    = opt_reg;
        if (load) begin
            valid_next = 1'b1;
            beat_next  = 1'b0;
            if (res.kind == RES_REPLY) begin
                byte_next   = IAC_BYTE;
                remote_next = 1'b1;
                last_next   = 1'b0;
                verb_next   = res.reply_verb;
                opt_next    = res.data;
            end else begin
                byte_next   = res.data;
                remote_next = 1'b0;
                last_next   = 1'b1;
            end
        end else if (step) begin
            // advance through IAC, verb, option
            beat_next = 1'b1;
            if (!beat_reg) begin
                byte_next = verb_reg;
            end else begin
                byte_next = opt_reg;
                last_next = 1'b1;
            end
        end else if (done) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        remote_reg <= remote_next;
        last_reg   <= last_next;
        verb_reg   <= verb_next;
        opt_reg    <= opt_next;
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_to_remote = remote_reg;
    assign m_last      = last_reg;

endmodule

// ===== rtl/core/telnet_option_refusal_filter_core.sv =====
// Telnet receive filter: takes received bytes on s_ and yields the
// application data on m_ with m_to_remote low, or a three-word refusal
// (IAC WONT x for DO x, IAC DONT x for WILL x) with m_to_remote high and m_last
// on the option word. Commands, DONT/WONT and subnegotiations produce no word.
// A byte passes the input register and then the output register before its
// first word appears. Throughput is one byte per cycle when nothing stalls; a
// refusal holds the output register for its three words, during which the input
// register takes one more byte and bytes that produce no word keep flowing.
module telnet_option_refusal_filter_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_to_remote,
    output logic       m_last
);
    import tofc_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic [7:0] in_byte_next;
    result_t    res;
    logic       has_out;
    logic       can_load;
    logic       consume;
    logic       load;

    assign has_out = (res.kind == RES_DATA) || (res.kind == RES_REPLY);
    assign consume = in_valid_reg && (!has_out || can_load);
    assign load    = consume && has_out;
    assign s_ready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    tofc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (in_byte_reg),
        .advance (consume),
        .res     (res)
    );

    tofc_emitter u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .res         (res),
        .can_load    (can_load),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_to_remote (m_to_remote),
        .m_last      (m_last)
    );

endmodule

// ===== rtl/core/tofc_checker.sv =====
module tofc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_to_remote,
    input logic       m_last
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
        $stable(m_to_remote) && $stable(m_last))
        else $error("stalled output word changed");

    // data words are always single
    a_data_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_to_remote |-> m_last)
        else $error("data word without last");

    // a reply runs on in the next cycle without a gap
    a_reply_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_to_remote && !m_last |=> m_valid && m_to_remote)
        else $error("reply broken up");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind telnet_option_refusal_filter_core tofc_checker u_tofc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_to_remote (m_to_remote),
    .m_last      (m_last)
);

// ===== tb/tb_telnet_option_refusal_filter_core.sv =====
module tb_telnet_option_refusal_filter_core;
    import tofc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_remote;
        logic       last;
    } filter_word_t;

    // Tracks the telnet receive state and the words the filter owes.
    class refusal_tracker;
        phase_t       rx_phase;
        verb_t        held_verb;
        filter_word_t words_due[$];
        int unsigned  faults;

        function new();
            rx_phase  = PH_DATA;
            held_verb = VERB_DO;
            faults    = 0;
        endfunction

        function void take_rx_byte(logic [7:0] b);
            logic       refuse;
            logic [7:0] answer;
            refuse = 1'b0;
            answer = WONT_BYTE;
            case (rx_phase)
                PH_IAC: begin
                    if (b == IAC_BYTE) begin
                        rx_phase = PH_DATA;
                        words_due.push_back('{IAC_BYTE, 1'b0, 1'b1});
                    end else if (b == DO_BYTE || b == DONT_BYTE ||
                                 b == WILL_BYTE || b == WONT_BYTE) begin
                        held_verb = (b == DO_BYTE)   ? VERB_DO :
                                    (b == DONT_BYTE) ? VERB_DONT :
                                    (b == WILL_BYTE) ? VERB_WILL : VERB_WONT;
                        rx_phase = PH_VERB;
                    end else begin
                        rx_phase = (b == SB_BYTE) ? PH_SUB : PH_DATA;
                    end
                end
                PH_VERB: begin
                    rx_phase = PH_DATA;
                    // refuse DO with WONT and WILL with DONT, swallow the rest
                    if (held_verb == VERB_DO) begin
                        refuse = 1'b1;
                        answer = WONT_BYTE;
                    end else if (held_verb == VERB_WILL) begin
                        refuse = 1'b1;
                        answer = DONT_BYTE;
                    end
                end
                PH_SUB: begin
                    rx_phase = (b == IAC_BYTE) ? PH_SUBIAC : PH_SUB;
                end
                PH_SUBIAC: begin
                    rx_phase = (b == SE_BYTE) ? PH_DATA : PH_SUB;
                end
                default: begin
                    if (b == IAC_BYTE) begin
                        rx_phase = PH_IAC;
                    end else begin
                        rx_phase = PH_DATA;
                        words_due.push_back('{b, 1'b0, 1'b1});
                    end
                end
            endcase
            if (refuse) begin
                words_due.push_back('{IAC_BYTE, 1'b1, 1'b0});
                words_due.push_back('{answer, 1'b1, 1'b0});
                words_due.push_back('{b, 1'b1, 1'b1});
            end
        endfunction

        function void match_word(logic [7:0] ob, logic rem, logic lst);
            filter_word_t due;
            if (words_due.size() == 0) begin
                $error("unexpected word: out_byte %0h to_remote %0b last %0b", ob, rem, lst);
                faults++;
                return;
            end
            due = words_due.pop_front();
            if (ob !== due.out_byte) begin
                $error("out_byte: expected %0h actual %0h", due.out_byte, ob);
                faults++;
            end
            if (rem !== due.to_remote) begin
                $error("to_remote: expected %0b actual %0b", due.to_remote, rem);
                faults++;
            end
            if (lst !== due.last) begin
                $error("last: expected %0b actual %0b", due.last, lst);
                faults++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_to_remote;
    logic       m_last;

    int unsigned send_idle_pct = 29;
    int unsigned recv_idle_pct = 51;
    int unsigned bytes_sent = 0;

    refusal_tracker tracker;

    logic [7:0] opening_bytes [26] = '{
        8'h00, 8'hAA, 8'h55,
        IAC_BYTE, IAC_BYTE,
        IAC_BYTE, DO_BYTE, 8'h00,
        IAC_BYTE, WILL_BYTE, 8'hFF,
        IAC_BYTE, DONT_BYTE, 8'h05,
        IAC_BYTE, WONT_BYTE, 8'h06,
        IAC_BYTE, SB_BYTE, IAC_BYTE, IAC_BYTE, SE_BYTE, IAC_BYTE, SE_BYTE,
        IAC_BYTE, 8'hF1
    };

    telnet_option_refusal_filter_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_to_remote (m_to_remote),
        .m_last      (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_word(m_out_byte, m_to_remote, m_last);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_sequence();
        int unsigned pick;
        int unsigned body_len;
        logic [7:0]  body;
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_byte(8'($urandom_range(254)));
        end else if (pick < 43) begin
            send_byte(IAC_BYTE);
            send_byte(IAC_BYTE);
        end else if (pick < 70) begin
            send_byte(IAC_BYTE);
            case ($urandom_range(3))
                0: send_byte(DO_BYTE);
                1: send_byte(DONT_BYTE);
                2: send_byte(WILL_BYTE);
                default: send_byte(WONT_BYTE);
            endcase
            send_byte(8'($urandom_range(255)));
        end else if (pick < 80) begin
            send_byte(IAC_BYTE);
            send_byte(SB_BYTE);
            body_len = $urandom_range(4);
            repeat (body_len) begin
                body = 8'($urandom_range(255));
                send_byte(body);
                // escaped byte inside the subnegotiation, never SE
                if (body == IAC_BYTE) send_byte(8'($urandom_range(238)));
            end
            send_byte(IAC_BYTE);
            send_byte(SE_BYTE);
        end else if (pick < 87) begin
            send_byte(IAC_BYTE);
            send_byte(8'($urandom_range(249)));
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic drain_words();
        s_valid <= 1'b0;
        while (tracker.words_due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int unsigned stop_at;
        tracker = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
        // hold the sender off until every owed word is out
        drain_words();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 51;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            stop_at = bytes_sent + 45;
            while (bytes_sent < stop_at) send_sequence();
        end

        drain_words();
        repeat (10) @(posedge aclk);
        if (tracker.faults == 0 && tracker.words_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== telnet_option_refusal_filter_core.f =====
rtl/core/tofc_pkg.sv
rtl/core/tofc_parser.sv
rtl/core/tofc_emitter.sv
rtl/core/telnet_option_refusal_filter_core.sv
rtl/core/tofc_checker.sv
tb/tb_telnet_option_refusal_filter_core.sv
